/* rtl/sctm_pkg.sv */
// Package for the scratchpad CRC temperature monitor.
// Item types, register indexes, reset values and the byte-wide CRC-8 update.
// No dependencies.
package sctm_pkg;

	localparam int LIMIT_SETS = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] CRC_POLY = 8'b1000_1100;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_C  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_C = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd6;

	localparam logic signed [15:0] RST_LOW_A  = 16'sd240;
	localparam logic signed [15:0] RST_HIGH_A = 16'sd320;
	localparam logic signed [15:0] RST_LOW_B  = 16'sd192;
	localparam logic signed [15:0] RST_HIGH_B = 16'sd400;
	localparam logic signed [15:0] RST_LOW_C  = 16'sd160;
	localparam logic signed [15:0] RST_HIGH_C = 16'sd448;
	localparam logic [7:0]         RST_DUTY   = 8'd200;

	typedef struct packed {
		logic [1:0] sensor_index;
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         result_sensor;
		logic               crc_ok;
		logic               reset_request;
		logic signed [15:0] temperature;
		logic               below_low;
		logic               above_high;
		logic               alarm_light;
		logic [7:0]         buzzer_duty;
	} out_item_t;

	// finished frame handed from front to back
	typedef struct packed {
		logic [1:0]         sensor;
		logic               crc_ok;
		logic signed [15:0] temp;
	} frame_rec_t;

	// reflected CRC-8, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		logic       mix;
		c = crc_in;
		d = b;
		for (int k = 0; k < 8; k++) begin
			mix = c[0] ^ d[0];
			c = c >> 1;
			d = d >> 1;
			if (mix) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/sctm_front.sv */
// Front end: accepts bytes, tracks frame position, runs the CRC.
// Pushes one frame record per completed frame. Uses sctm_pkg.
module sctm_front #(
	parameter int NUM_SENSORS = 3,
	parameter int FRAME_BYTES = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  sctm_pkg::in_item_t   item,
	output logic                 push,
	output sctm_pkg::frame_rec_t rec
);
	import sctm_pkg::*;

	localparam int NSENS = (NUM_SENSORS < LIMIT_SETS) ? NUM_SENSORS : LIMIT_SETS;
	localparam int PW    = $clog2(FRAME_BYTES + 1);
	localparam logic [PW-1:0] POS_LAST = PW'(FRAME_BYTES - 1);
	localparam logic [PW-1:0] POS_IDLE = PW'(FRAME_BYTES);

	logic [7:0]    crc_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    lo_q;
	logic [7:0]    hi_q;

	logic          s_ok;
	logic          take;
	logic [PW-1:0] pos_eff;
	logic [7:0]    crc_eff;

	assign s_ok    = item.sensor_index < 2'(NSENS);
	assign take    = acc && s_ok;
	assign pos_eff = item.frame_start ? '0 : pos_q;
	assign crc_eff = item.frame_start ? 8'h00 : crc_q;

	assign push        = take && (pos_eff == POS_LAST);
	assign rec.sensor  = item.sensor_index;
	assign rec.crc_ok  = (crc_eff == item.data_byte);
	assign rec.temp    = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
			pos_q <= POS_IDLE;
			lo_q  <= 8'h00;
			hi_q  <= 8'h00;
		end else if (take) begin
			if (pos_eff < POS_LAST) begin
				crc_q <= crc8_byte(crc_eff, item.data_byte);
				pos_q <= pos_eff + 1'b1;
				if (pos_eff == '0) begin
					lo_q <= item.data_byte;
				end
				if (pos_eff == PW'(1)) begin
					hi_q <= item.data_byte;
				end
			end else if (pos_eff == POS_LAST) begin
				pos_q <= POS_IDLE;
			end
		end
	end

endmodule

/* rtl/sctm_queue.sv */
// Two-entry frame record queue between front and back.
// Uses sctm_pkg for the record type.
module sctm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sctm_pkg::frame_rec_t wr_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 nonempty,
	output sctm_pkg::frame_rec_t rd_rec
);
	import sctm_pkg::*;

	frame_rec_t  slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rd_rec   = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* rtl/sctm_back.sv */
// Back end: window check, per-sensor temperature and light store, buzzer duty,
// configuration registers and the output register. Uses sctm_pkg.
module sctm_back #(
	parameter int NUM_SENSORS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rec_valid,
	input  sctm_pkg::frame_rec_t                 rec,
	output logic                                 pop,
	input  logic                                 cfg_we,
	input  logic [sctm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sctm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output sctm_pkg::out_item_t                  out_item
);
	import sctm_pkg::*;

	localparam int NSENS = (NUM_SENSORS < LIMIT_SETS) ? NUM_SENSORS : LIMIT_SETS;
	localparam int SW    = (NSENS > 1) ? $clog2(NSENS) : 1;

	logic signed [15:0] low_q   [LIMIT_SETS];
	logic signed [15:0] high_q  [LIMIT_SETS];
	logic [7:0]         duty_cfg_q;

	logic signed [15:0] temps_q  [NSENS];
	logic               lights_q [NSENS];
	logic [7:0]         duty_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic [SW-1:0]      sel;
	logic               below;
	logic               above;
	logic               outside;
	out_item_t          nxt;

	assign pop       = rec_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign sel       = rec.sensor[SW-1:0];

	always_comb begin
		below   = rec.crc_ok && (rec.temp < low_q[rec.sensor]);
		above   = rec.crc_ok && (rec.temp > high_q[rec.sensor]);
		outside = below || above;
		nxt.result_sensor = rec.sensor;
		nxt.crc_ok        = rec.crc_ok;
		nxt.reset_request = !rec.crc_ok;
		nxt.below_low     = below;
		nxt.above_high    = above;
		if (rec.crc_ok) begin
			nxt.temperature = rec.temp;
			nxt.alarm_light = outside;
			nxt.buzzer_duty = outside ? duty_cfg_q : 8'h00;
		end else begin
			// failed frame shows the kept values
			nxt.temperature = temps_q[sel];
			nxt.alarm_light = lights_q[sel];
			nxt.buzzer_duty = duty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q[0]   <= RST_LOW_A;
			high_q[0]  <= RST_HIGH_A;
			low_q[1]   <= RST_LOW_B;
			high_q[1]  <= RST_HIGH_B;
			low_q[2]   <= RST_LOW_C;
			high_q[2]  <= RST_HIGH_C;
			duty_cfg_q <= RST_DUTY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_A:  low_q[0]   <= cfg_data;
				REG_HIGH_A: high_q[0]  <= cfg_data;
				REG_LOW_B:  low_q[1]   <= cfg_data;
				REG_HIGH_B: high_q[1]  <= cfg_data;
				REG_LOW_C:  low_q[2]   <= cfg_data;
				REG_HIGH_C: high_q[2]  <= cfg_data;
				REG_DUTY:   duty_cfg_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSENS; i++) begin
				temps_q[i]  <= '0;
				lights_q[i] <= 1'b0;
			end
			duty_q      <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && rec.crc_ok) begin
				temps_q[sel]  <= rec.temp;
				lights_q[sel] <= nxt.alarm_light;
				duty_q        <= nxt.buzzer_duty;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= nxt;
		end
	end

endmodule

/* rtl/scratchpad_crc_temperature_monitor_unit.sv */
// Top level of the scratchpad CRC temperature monitor.
// Instantiates sctm_front, sctm_queue and sctm_back; uses sctm_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item  (sensor_index, data_byte, frame_start)
//   out      output     out_valid / out_ready  out_item (one per completed frame)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One byte item per cycle while the queue is not full; the front CRC update is one byte a cycle.
// A frame result passes through the queue, then the output register, after its
// last byte is taken. in_ready drops only while the two-entry queue is full.
// Reset clears frame tracking, stored temperatures, lights and duty at once;
// limits and alarm duty return to their default values.
module scratchpad_crc_temperature_monitor_unit #(
	parameter int NUM_SENSORS = 3,
	parameter int FRAME_BYTES = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sctm_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sctm_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [sctm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sctm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sctm_pkg::*;

	logic       push;
	logic       q_full;
	logic       q_nonempty;
	logic       pop;
	frame_rec_t wr_rec;
	frame_rec_t rd_rec;

	assign in_ready = !q_full;

	sctm_front #(
		.NUM_SENSORS(NUM_SENSORS),
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.acc   (in_valid && in_ready),
		.item  (in_item),
		.push  (push),
		.rec   (wr_rec)
	);

	sctm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_rec  (wr_rec),
		.full    (q_full),
		.pop     (pop),
		.nonempty(q_nonempty),
		.rd_rec  (rd_rec)
	);

	sctm_back #(
		.NUM_SENSORS(NUM_SENSORS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(q_nonempty),
		.rec      (rd_rec),
		.pop      (pop),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

/* rtl/sctm_checker.sv */
// Port-level checks for the scratchpad CRC temperature monitor.
// Bound to scratchpad_crc_temperature_monitor_unit; uses sctm_pkg.
module sctm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input sctm_pkg::out_item_t out_item
);
	import sctm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_ok_vs_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.crc_ok != out_item.reset_request)
		else $error("crc_ok and reset_request disagree");

	a_fail_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.crc_ok |-> !out_item.below_low && !out_item.above_high)
		else $error("window flags set on failed frame");

	a_light_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.crc_ok
		|-> out_item.alarm_light == (out_item.below_low || out_item.above_high))
		else $error("alarm light does not follow window check");

	a_quiet_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.crc_ok && !out_item.alarm_light |-> out_item.buzzer_duty == 8'h00)
		else $error("buzzer on while sensor inside window");

endmodule

bind scratchpad_crc_temperature_monitor_unit sctm_checker u_sctm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
